// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the ray generator.
// No dependencies; pulled in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> cons) \
    else $error("assertion violated");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> cons) \
    else $error("assertion violated");

`endif

// ===== rtl/cvrg_pkg.sv =====
// Package of the camera view ray generator: defaults, fixed-point constants
// and register indexes. No dependencies.
package cvrg_pkg;

  localparam int unsigned PixelCoordBitsDef = 16;
  localparam int unsigned CoeffFracBitsDef  = 16;

  localparam int unsigned PixBits   = 16;  // width of the pixel ports
  localparam int unsigned PixFrac   = 4;   // Q12.4 screen coordinates
  localparam int unsigned DivQBits  = 31;  // quotient bits below saturation
  localparam int unsigned SqrtBits  = 31;  // root bits of the length
  localparam int unsigned DirQBits  = 16;  // quotient bits of a component
  localparam int unsigned DirFrac   = 14;  // Q2.14 direction
  localparam int unsigned NormTop   = 29;  // largest magnitude in [2^29, 2^30)
  localparam int          UnitOne   = 16384;

  localparam logic signed [31:0] Int32Max = 32'sh7fff_ffff;
  localparam logic signed [31:0] Int32Min = 32'sh8000_0000;

  typedef enum logic [2:0] {
    CfgRowX   = 3'd0,
    CfgRowY   = 3'd1,
    CfgRowZ   = 3'd2,
    CfgRowW   = 3'd3,
    CfgOffXy  = 3'd4,
    CfgOffZw  = 3'd5,
    CfgCamXy  = 3'd6,
    CfgCamZ   = 3'd7
  } cfg_idx_e;

endpackage

// ===== rtl/camera_view_ray_generator.sv =====
// Camera view ray generator: screen point in, unit view direction out.
// Depends on cvrg_pkg and assert_macros.svh.
//
// Usage:
//  - Input: a transaction is taken at a rising edge with start_i high and
//    busy_o low. busy_o stays low: the pipeline takes one point every cycle.
//  - Output: done_o is high for exactly one cycle per transaction, with
//    dir_x_o/dir_y_o/dir_z_o (Q2.14) and degenerate_o. Results leave in
//    input order.
//  - Throughput: one point per clock, sustained. The pipeline holds the two
//    bit-per-stage dividers (31 and 16 stages) and the bit-per-stage
//    square root (31 stages), plus 12 arithmetic stages.
//  - Config: cfg_we_i/cfg_idx_i/cfg_wdata_i write one register per cycle.
//    Users write registers only with no transaction in flight; unenforced.
//  - Reset (rst_ni low, async) clears the config and valid registers and
//    drops every in-flight transaction; payload stages are not reset.
//  - The receiver cannot stall: done_o is a strobe, not a handshake.
module camera_view_ray_generator
  import cvrg_pkg::*;
#(
  parameter int unsigned PixelCoordBits = PixelCoordBitsDef,
  parameter int unsigned CoeffFracBits  = CoeffFracBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [PixBits-1:0]        pixel_x_i,
  input  logic [PixBits-1:0]        pixel_y_i,
  input  logic                      cfg_we_i,
  input  logic [2:0]                cfg_idx_i,
  input  logic [63:0]               cfg_wdata_i,
  output logic                      done_o,
  output logic signed [15:0]        dir_x_o,
  output logic signed [15:0]        dir_y_o,
  output logic signed [15:0]        dir_z_o,
  output logic                      degenerate_o
);

  // Pixel bits actually used: the port caps the configured width.
  localparam int unsigned PxBits = (PixelCoordBits < PixBits) ? PixelCoordBits : PixBits;
  localparam int unsigned PW     = 32 + PxBits + 1;        // product width
  localparam int unsigned AW     = PW + 2;                 // row sum width
  localparam int unsigned NW     = 32 + CoeffFracBits;     // dividend width
  localparam int unsigned Lat    = 3 + DivQBits + 7 + SqrtBits + 1 + DirQBits + 1;

  typedef struct packed {
    logic [2:0]        sgn;
    logic              deg;
    logic [2:0][29:0]  nm;
  } side_t;

  // ------------------------------------------------------------------
  // Configuration registers
  // ------------------------------------------------------------------
  logic [63:0]        row_q [4];
  logic [63:0]        off_q [2];
  logic [63:0]        cam_xy_q;
  logic signed [31:0] cam_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 4; r++) row_q[r] <= '0;
      off_q[0] <= '0;
      off_q[1] <= '0;
      cam_xy_q <= '0;
      cam_z_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgRowX:  row_q[0] <= cfg_wdata_i;
        CfgRowY:  row_q[1] <= cfg_wdata_i;
        CfgRowZ:  row_q[2] <= cfg_wdata_i;
        CfgRowW:  row_q[3] <= cfg_wdata_i;
        CfgOffXy: off_q[0] <= cfg_wdata_i;
        CfgOffZw: off_q[1] <= cfg_wdata_i;
        CfgCamXy: cam_xy_q <= cfg_wdata_i;
        CfgCamZ:  cam_z_q  <= signed'(cfg_wdata_i[31:0]);
      endcase
    end
  end

  logic signed [31:0] offs [4];
  logic signed [31:0] cam  [3];
  assign offs[0] = signed'(off_q[0][31:0]);
  assign offs[1] = signed'(off_q[0][63:32]);
  assign offs[2] = signed'(off_q[1][31:0]);
  assign offs[3] = signed'(off_q[1][63:32]);
  assign cam[0]  = signed'(cam_xy_q[31:0]);
  assign cam[1]  = signed'(cam_xy_q[63:32]);
  assign cam[2]  = cam_z_q;

  // ------------------------------------------------------------------
  // Valid chain: one bit per stage, travels with the payload
  // ------------------------------------------------------------------
  logic [Lat:1] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-1:1], start_i & ~busy_o};
    end
  end

  assign busy_o = 1'b0;  // fully pipelined, never holds off a start

  // ------------------------------------------------------------------
  // Stage 1: coefficient x pixel products
  // ------------------------------------------------------------------
  logic signed [PxBits:0] px_s, py_s;
  logic signed [PW-1:0]   pa_q [4];
  logic signed [PW-1:0]   pb_q [4];

  assign px_s = signed'({1'b0, pixel_x_i[PxBits-1:0]});
  assign py_s = signed'({1'b0, pixel_y_i[PxBits-1:0]});

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 4; r++) begin
      pa_q[r] <= PW'(signed'(row_q[r][31:0])) * PW'(px_s);
      pb_q[r] <= PW'(signed'(row_q[r][63:32])) * PW'(py_s);
    end
  end

  // ------------------------------------------------------------------
  // Stage 2: row sums, round half away from zero, saturate to 32 bits
  // ------------------------------------------------------------------
  logic signed [31:0] h_d [4];
  logic signed [31:0] h_q [4];

  always_comb begin
    logic signed [AW-1:0] acc;
    logic [AW-1:0]        amag;
    logic [AW-1:0]        rm;
    for (int r = 0; r < 4; r++) begin
      acc  = AW'(pa_q[r]) + AW'(pb_q[r]) + (AW'(offs[r]) <<< PixFrac);
      amag = acc[AW-1] ? AW'(-acc) : AW'(acc);
      rm   = (amag + AW'(1 << (PixFrac - 1))) >> PixFrac;
      if (!acc[AW-1]) begin
        h_d[r] = (rm > AW'(Int32Max)) ? Int32Max : signed'(rm[31:0]);
      end else begin
        h_d[r] = (rm > AW'(64'h8000_0000)) ? Int32Min : -signed'(rm[31:0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 4; r++) h_q[r] <= h_d[r];
  end

  // ------------------------------------------------------------------
  // Stage 3 + 31 steps: perspective divide, one quotient bit per stage.
  // Dividend (|v| << frac) + |w|/2; a quotient at or above 2^31 saturates,
  // so only the low 31 bits are developed.
  // ------------------------------------------------------------------
  logic [31:0]   dr_q   [DivQBits+1][3];
  logic [30:0]   dlo_q  [DivQBits+1][3];
  logic [31:0]   dd_q   [DivQBits+1];
  logic [2:0]    dovf_q [DivQBits+1];
  logic [2:0]    dneg_q [DivQBits+1];
  logic          ddeg_q [DivQBits+1];

  always_ff @(posedge clk_i) begin
    logic [31:0]   xm;
    logic [31:0]   wm;
    logic [NW-1:0] np;
    wm = h_q[3][31] ? 32'(-h_q[3]) : 32'(h_q[3]);
    for (int j = 0; j < 3; j++) begin
      xm = h_q[j][31] ? 32'(-h_q[j]) : 32'(h_q[j]);
      np = (NW'(xm) << CoeffFracBits) + NW'(wm >> 1);
      dr_q[0][j]   <= 32'(np >> DivQBits);
      dlo_q[0][j]  <= np[DivQBits-1:0];
      dovf_q[0][j] <= 64'(np) >= {1'b0, wm, 31'd0};
      dneg_q[0][j] <= h_q[j][31] ^ h_q[3][31];
    end
    dd_q[0]   <= wm;
    ddeg_q[0] <= (h_q[3] == 32'sd0);
  end

  for (genvar k = 0; k < DivQBits; k++) begin : g_div
    always_ff @(posedge clk_i) begin
      logic [32:0] t;
      logic        ge;
      for (int j = 0; j < 3; j++) begin
        t  = {dr_q[k][j], dlo_q[k][j][DivQBits-1]};
        ge = t >= {1'b0, dd_q[k]};
        dr_q[k+1][j]  <= ge ? 32'(t - {1'b0, dd_q[k]}) : 32'(t);
        dlo_q[k+1][j] <= {dlo_q[k][j][DivQBits-2:0], ge};
      end
      dd_q[k+1]   <= dd_q[k];
      dovf_q[k+1] <= dovf_q[k];
      dneg_q[k+1] <= dneg_q[k];
      ddeg_q[k+1] <= ddeg_q[k];
    end
  end

  // ------------------------------------------------------------------
  // Stage 4: signed quotient, camera position subtracted (exact)
  // ------------------------------------------------------------------
  logic signed [33:0] d4_q [3];
  logic               deg4_q;

  always_ff @(posedge clk_i) begin
    logic signed [31:0] p;
    for (int j = 0; j < 3; j++) begin
      if (dovf_q[DivQBits][j]) begin
        p = dneg_q[DivQBits][j] ? Int32Min : Int32Max;
      end else begin
        p = dneg_q[DivQBits][j] ? -signed'({1'b0, dlo_q[DivQBits][j]})
                                 :  signed'({1'b0, dlo_q[DivQBits][j]});
      end
      d4_q[j] <= 34'(p) - 34'(cam[j]);
    end
    deg4_q <= ddeg_q[DivQBits];
  end

  // Stage 5: magnitudes and signs
  logic [32:0] mag5_q [3];
  logic [2:0]  sgn5_q;
  logic        deg5_q;

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      mag5_q[j] <= d4_q[j][33] ? 33'(-d4_q[j]) : 33'(d4_q[j]);
      sgn5_q[j] <= d4_q[j][33];
    end
    deg5_q <= deg4_q;
  end

  // Stage 6: largest magnitude; an all-zero difference is degenerate
  logic [32:0] mag6_q [3];
  logic [32:0] mx6_q;
  logic [2:0]  sgn6_q;
  logic        deg6_q;

  always_ff @(posedge clk_i) begin
    logic [32:0] m01;
    logic [32:0] mx;
    m01 = (mag5_q[0] > mag5_q[1]) ? mag5_q[0] : mag5_q[1];
    mx  = (m01 > mag5_q[2]) ? m01 : mag5_q[2];
    for (int j = 0; j < 3; j++) mag6_q[j] <= mag5_q[j];
    mx6_q  <= mx;
    sgn6_q <= sgn5_q;
    deg6_q <= deg5_q | (mx == '0);
  end

  // Stage 7: leading-one position of the largest magnitude
  logic [32:0] mag7_q [3];
  logic [5:0]  pos7_q;
  logic [2:0]  sgn7_q;
  logic        deg7_q;

  always_ff @(posedge clk_i) begin
    logic [5:0] pos;
    pos = '0;
    for (int i = 0; i < 33; i++) begin
      if (mx6_q[i]) pos = 6'(i);
    end
    for (int j = 0; j < 3; j++) mag7_q[j] <= mag6_q[j];
    pos7_q <= pos;
    sgn7_q <= sgn6_q;
    deg7_q <= deg6_q;
  end

  // Stage 8: common shift so the largest lands in [2^29, 2^30)
  side_t side8_q;

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      if (pos7_q > 6'(NormTop)) begin
        side8_q.nm[j] <= 30'(mag7_q[j] >> (pos7_q - 6'(NormTop)));
      end else begin
        side8_q.nm[j] <= 30'(mag7_q[j] << (6'(NormTop) - pos7_q));
      end
    end
    side8_q.sgn <= sgn7_q;
    side8_q.deg <= deg7_q;
  end

  // Stage 9: squares
  logic [59:0] sq9_q [3];
  side_t       side9_q;

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      sq9_q[j] <= 60'(side8_q.nm[j]) * 60'(side8_q.nm[j]);
    end
    side9_q <= side8_q;
  end

  // ------------------------------------------------------------------
  // Stage 10 + 31 steps: sum of squares, then floor square root, one
  // root bit per stage (remainder kept as sum - root^2).
  // ------------------------------------------------------------------
  logic [61:0] sr_q    [SqrtBits+1];
  logic [30:0] rt_q    [SqrtBits+1];
  side_t       sside_q [SqrtBits+1];

  always_ff @(posedge clk_i) begin
    sr_q[0]    <= 62'(sq9_q[0]) + 62'(sq9_q[1]) + 62'(sq9_q[2]);
    rt_q[0]    <= '0;
    sside_q[0] <= side9_q;
  end

  for (genvar t = 0; t < SqrtBits; t++) begin : g_sqrt
    localparam int unsigned K = SqrtBits - 1 - t;
    always_ff @(posedge clk_i) begin
      logic [63:0] trial;
      logic        ge;
      trial = (64'(rt_q[t]) << (K + 1)) + (64'd1 << (2 * K));
      ge    = 64'(sr_q[t]) >= trial;
      sr_q[t+1]    <= ge ? 62'(64'(sr_q[t]) - trial) : sr_q[t];
      rt_q[t+1]    <= ge ? (rt_q[t] | (31'd1 << K)) : rt_q[t];
      sside_q[t+1] <= sside_q[t];
    end
  end

  // ------------------------------------------------------------------
  // Component scaling: round(nm * 2^14 / len), one bit per stage.
  // nm < 2^30 and len >= 2^29 keep the quotient within 16 bits.
  // ------------------------------------------------------------------
  logic [30:0] fr_q    [DirQBits+1][3];
  logic [15:0] flo_q   [DirQBits+1][3];
  logic [30:0] fd_q    [DirQBits+1];
  side_t       fside_q [DirQBits+1];

  always_ff @(posedge clk_i) begin
    logic [44:0] np2;
    logic [30:0] len;
    len = rt_q[SqrtBits];
    for (int j = 0; j < 3; j++) begin
      np2 = (45'(sside_q[SqrtBits].nm[j]) << DirFrac) + 45'(len >> 1);
      fr_q[0][j]  <= 31'(np2 >> DirQBits);
      flo_q[0][j] <= np2[DirQBits-1:0];
    end
    fd_q[0]    <= len;
    fside_q[0] <= sside_q[SqrtBits];
  end

  for (genvar k = 0; k < DirQBits; k++) begin : g_fdiv
    always_ff @(posedge clk_i) begin
      logic [31:0] t;
      logic        ge;
      for (int j = 0; j < 3; j++) begin
        t  = {fr_q[k][j], flo_q[k][j][DirQBits-1]};
        ge = t >= {1'b0, fd_q[k]};
        fr_q[k+1][j]  <= ge ? 31'(t - {1'b0, fd_q[k]}) : 31'(t);
        flo_q[k+1][j] <= {flo_q[k][j][DirQBits-2:0], ge};
      end
      fd_q[k+1]    <= fd_q[k];
      fside_q[k+1] <= fside_q[k];
    end
  end

  // ------------------------------------------------------------------
  // Output stage: clamp to one, apply sign, zero out degenerate rays
  // ------------------------------------------------------------------
  logic signed [15:0] dir_q [3];
  logic               deg_q;

  always_ff @(posedge clk_i) begin
    logic [15:0] c;
    for (int j = 0; j < 3; j++) begin
      c = flo_q[DirQBits][j];
      if (c > 16'(UnitOne)) c = 16'(UnitOne);
      if (fside_q[DirQBits].deg) begin
        dir_q[j] <= '0;
      end else begin
        dir_q[j] <= fside_q[DirQBits].sgn[j] ? -signed'(c) : signed'(c);
      end
    end
    deg_q <= fside_q[DirQBits].deg;
  end

  assign done_o       = vld_q[Lat];
  assign dir_x_o      = dir_q[0];
  assign dir_y_o      = dir_q[1];
  assign dir_z_o      = dir_q[2];
  assign degenerate_o = deg_q;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
`include "assert_macros.svh"

  `ASSERT_IMPL(a_fixed_latency, clk_i, rst_ni, start_i && !busy_o, ##Lat done_o)
  `ASSERT_IMPL(a_degenerate_zero, clk_i, rst_ni, done_o && degenerate_o, dir_x_o == 16'sd0 && dir_y_o == 16'sd0 && dir_z_o == 16'sd0)
  `ASSERT_IMPL(a_unit_range, clk_i, rst_ni, done_o && !degenerate_o, dir_x_o <= UnitOne && dir_x_o >= -UnitOne && dir_z_o <= UnitOne && dir_z_o >= -UnitOne)
  `ASSERT_NEXT(a_w_zero_flag, clk_i, rst_ni, vld_q[2] && h_q[3] == 32'sd0, ddeg_q[0])

endmodule

// ===== test/tb.sv =====
// Testbench of camera_view_ray_generator: drives screen points and register
// writes, predicts each unit view direction and checks it. Needs cvrg_pkg.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cvrg_pkg::*;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               deg;
  } ray_dir_t;

  // Scoreboard: register mirror, direction predictor and expected queue.
  class ray_dir_scoreboard;
    logic [63:0] regs [8];
    ray_dir_t    expected_dirs [$];
    int          errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      errors = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [63:0] val);
      regs[idx] = (idx == CfgCamZ) ? {32'b0, val[31:0]} : val;
    endfunction

    static function longint lo_word(logic [63:0] r);
      return longint'($signed(r[31:0]));
    endfunction

    static function longint hi_word(logic [63:0] r);
      return longint'($signed(r[63:32]));
    endfunction

    static function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // round v / 2^sh, half away from zero
    static function longint round_down(longint v, int sh);
      longint half;
      half = longint'(1) <<< (sh - 1);
      if (v >= 0) return (v + half) >>> sh;
      return -((-v + half) >>> sh);
    endfunction

    static function longint row_value(logic [63:0] co, longint off, longint px, longint py);
      longint acc;
      acc = lo_word(co) * px + hi_word(co) * py + off * 16;
      return clip32(round_down(acc, PixFrac));
    endfunction

    static function longint quot_round(longint num, longint den);
      longint unsigned n, d, q;
      longint r;
      n = longint'(num < 0 ? -num : num) << CoeffFracBitsDef;
      d = (den < 0) ? -den : den;
      q = (n + (d >> 1)) / d;
      if (q > (64'd1 << 32)) q = 64'd1 << 32;
      r = longint'(q);
      if ((num < 0) != (den < 0)) r = -r;
      return clip32(r);
    endfunction

    static function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function void note_point(logic [15:0] pix_x, logic [15:0] pix_y);
      ray_dir_t e;
      longint px, py, hx, hy, hz, hw;
      longint d [3];
      longint unsigned mag [3], mx, sum, len, c;
      longint s;
      px = longint'(pix_x);
      py = longint'(pix_y);
      e = '{x: 0, y: 0, z: 0, deg: 1'b1};
      hx = row_value(regs[CfgRowX], lo_word(regs[CfgOffXy]), px, py);
      hy = row_value(regs[CfgRowY], hi_word(regs[CfgOffXy]), px, py);
      hz = row_value(regs[CfgRowZ], lo_word(regs[CfgOffZw]), px, py);
      hw = row_value(regs[CfgRowW], hi_word(regs[CfgOffZw]), px, py);
      if (hw != 0) begin
        d[0] = quot_round(hx, hw) - lo_word(regs[CfgCamXy]);
        d[1] = quot_round(hy, hw) - hi_word(regs[CfgCamXy]);
        d[2] = quot_round(hz, hw) - lo_word(regs[CfgCamZ]);
        mx = 0;
        for (int i = 0; i < 3; i++) begin
          mag[i] = (d[i] < 0) ? -d[i] : d[i];
          if (mag[i] > mx) mx = mag[i];
        end
        if (mx != 0) begin
          // bring the largest magnitude into [2^29, 2^30)
          while (mx >= (64'd1 << 30)) begin
            mx >>= 1;
            for (int i = 0; i < 3; i++) mag[i] >>= 1;
          end
          while (mx < (64'd1 << 29)) begin
            mx <<= 1;
            for (int i = 0; i < 3; i++) mag[i] <<= 1;
          end
          sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
          len = int_sqrt(sum);
          for (int i = 0; i < 3; i++) begin
            c = ((mag[i] << DirFrac) + (len >> 1)) / len;
            if (c > UnitOne) c = UnitOne;
            s = longint'(c);
            if (d[i] < 0) s = -s;
            if (i == 0) e.x = s[15:0];
            else if (i == 1) e.y = s[15:0];
            else e.z = s[15:0];
          end
          e.deg = 1'b0;
        end
      end
      expected_dirs.push_back(e);
    endfunction

    function void check_dir(ray_dir_t got);
      ray_dir_t e;
      if (expected_dirs.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d z=%0d deg=%0b", $time,
                 got.x, got.y, got.z, got.deg);
        errors++;
        return;
      end
      e = expected_dirs.pop_front();
      if (got.x !== e.x) begin
        $display("%0t: dir_x expected %0d actual %0d", $time, e.x, got.x);
        errors++;
      end
      if (got.y !== e.y) begin
        $display("%0t: dir_y expected %0d actual %0d", $time, e.y, got.y);
        errors++;
      end
      if (got.z !== e.z) begin
        $display("%0t: dir_z expected %0d actual %0d", $time, e.z, got.z);
        errors++;
      end
      if (got.deg !== e.deg) begin
        $display("%0t: degenerate expected %0b actual %0b", $time, e.deg, got.deg);
        errors++;
      end
    endfunction
  endclass

  localparam int WatchdogLimit = 5000;
  localparam int DrainCycles   = 120;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [15:0]        pixel_x_i = '0;
  logic [15:0]        pixel_y_i = '0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_idx_i = '0;
  logic [63:0]        cfg_wdata_i = '0;
  logic               done_o;
  logic signed [15:0] dir_x_o, dir_y_o, dir_z_o;
  logic               degenerate_o;

  ray_dir_scoreboard sb = new();
  bit  calm;        // when set, the sender never idles
  bit  accepted;    // a transaction moved this cycle
  int  idle_cycles;

  camera_view_ray_generator dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .pixel_x_i, .pixel_y_i,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .done_o, .dir_x_o, .dir_y_o, .dir_z_o, .degenerate_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Result monitor: done_o is a one-cycle strobe, sampled at the closing edge.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      sb.check_dir('{x: dir_x_o, y: dir_y_o, z: dir_z_o, deg: degenerate_o});
    end
  end

  // Watchdog on cycles with no transaction in either direction.
  always @(posedge clk_i) begin
    if (accepted || (rst_ni && done_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic reg_write(cfg_idx_e idx, logic [63:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    cfg_we_i    <= 1'b0;
  endtask

  // Drain: registers change only with nothing in flight.
  task automatic wait_idle();
    while (sb.expected_dirs.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_point(logic [15:0] px, logic [15:0] py);
    accepted = 1'b0;
    while (!calm && $urandom_range(99) < 36) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i   <= 1'b1;
    pixel_x_i <= px;
    pixel_y_i <= py;
    do @(posedge clk_i); while (busy_o);
    accepted = 1'b1;
    sb.note_point(px, py);
  endtask

  task automatic stop_sending();
    start_i  <= 1'b0;
    @(posedge clk_i);
    accepted = 1'b0;
  endtask

  function automatic logic [31:0] pick_word(bit tame);
    case ($urandom_range(tame ? 2 : 5))
      0: return 32'($signed($urandom_range(524287)) - 262144);  // within +/-4.0
      1: return 32'($signed($urandom_range(8191)) - 4096);
      2: return '0;
      3: return $urandom();
      4: begin
        case ($urandom_range(4))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'hffff_ffff;
          3: return 32'h0001_0000;
          default: return 32'h0000_0001;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [15:0] pick_pixel();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'($urandom_range(15));
      3: return 16'($urandom_range(1023));
      default: return 16'($urandom());
    endcase
  endfunction

  // Random register set; tame sets keep w near a constant so most rays are
  // well formed, wild sets hit saturation and zero w.
  task automatic random_config(bit tame);
    reg_write(CfgRowX, {pick_word(tame), pick_word(tame)});
    reg_write(CfgRowY, {pick_word(tame), pick_word(tame)});
    reg_write(CfgRowZ, {pick_word(tame), pick_word(tame)});
    if (tame) begin
      reg_write(CfgRowW, {32'($urandom_range(3)), 32'($urandom_range(3))});
      reg_write(CfgOffZw, {32'($urandom_range(32'h40000, 32'h8000)), pick_word(1)});
    end else begin
      reg_write(CfgRowW, {pick_word(0), pick_word(0)});
      reg_write(CfgOffZw, {pick_word(0), pick_word(0)});
    end
    reg_write(CfgOffXy, {pick_word(tame), pick_word(tame)});
    reg_write(CfgCamXy, {pick_word(tame), pick_word(tame)});
    reg_write(CfgCamZ, {$urandom(), pick_word(tame)});
  endtask

  initial begin
    calm = 1'b0;
    accepted = 1'b0;
    idle_cycles = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset registers: w is zero, every ray is degenerate.
    send_point(16'h0000, 16'h0000);
    send_point(16'hffff, 16'hffff);
    send_point(16'h0001, 16'h8000);
    stop_sending();
    wait_idle();

    // Near identity: x=px, y=py, z=1, w=1. Camera at (0,0,1) makes the
    // origin pixel a zero-length ray.
    reg_write(CfgRowX, 64'h0000_0000_0001_0000);
    reg_write(CfgRowY, 64'h0001_0000_0000_0000);
    reg_write(CfgRowZ, 64'h0);
    reg_write(CfgRowW, 64'h0);
    reg_write(CfgOffXy, 64'h0);
    reg_write(CfgOffZw, 64'h0001_0000_0001_0000);
    reg_write(CfgCamXy, 64'h0);
    reg_write(CfgCamZ, 64'h0001_0000);
    calm = 1'b1;
    send_point(16'h0000, 16'h0000);
    send_point(16'h0010, 16'h0000);
    send_point(16'h0000, 16'h0010);
    send_point(16'hffff, 16'h0000);
    send_point(16'h0000, 16'hffff);
    send_point(16'hffff, 16'hffff);
    send_point(16'h8000, 16'h7fff);
    calm = 1'b0;
    stop_sending();
    wait_idle();

    // Extremes: rows saturate, negative camera, tiny and negative w.
    reg_write(CfgRowX, 64'h7fff_ffff_7fff_ffff);
    reg_write(CfgRowY, 64'h8000_0000_8000_0000);
    reg_write(CfgRowZ, 64'hffff_ffff_ffff_ffff);
    reg_write(CfgRowW, 64'h0);
    reg_write(CfgOffXy, 64'h8000_0000_7fff_ffff);
    reg_write(CfgOffZw, 64'hffff_ffff_7fff_ffff);
    reg_write(CfgCamXy, 64'h8000_0000_7fff_ffff);
    reg_write(CfgCamZ, 64'hffff_ffff_8000_0000);
    send_point(16'h0000, 16'h0000);
    send_point(16'hffff, 16'hffff);
    send_point(16'h0001, 16'h0000);
    send_point(16'h0000, 16'h0001);
    stop_sending();
    wait_idle();
    reg_write(CfgOffZw, 64'h0000_0001_7fff_ffff);  // w = 1 ulp: quotients saturate
    send_point(16'h0000, 16'h0000);
    send_point(16'hffff, 16'h0000);
    send_point(16'h5555, 16'haaaa);
    stop_sending();
    wait_idle();

    // Random phases; the third one runs with the sender never idling.
    for (int ph = 0; ph < 9; ph++) begin
      random_config($urandom_range(3) != 0);
      calm = (ph == 2);
      for (int n = 0; n < 205; n++) send_point(pick_pixel(), pick_pixel());
      calm = 1'b0;
      stop_sending();
      wait_idle();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_dirs.size() == 0) begin
      $display("tb OK");
    end else begin
      if (sb.expected_dirs.size() != 0)
        $display("%0t: %0d results never arrived", $time, sb.expected_dirs.size());
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/cvrg_pkg.sv
rtl/camera_view_ray_generator.sv
test/tb.sv
